@@ rtl/core/lpft_pkg.sv @@
// Package for the listening port filter table.
// Holds the table sizes, command and status codes and the item structs.
// No dependencies.
`default_nettype none

package lpft_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int CMD_W       = 2;
  localparam int PORT_W      = 16;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int PORT_CNT_W  = 9;
  localparam int MAX_W       = 9;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  // Width that holds both the held count and the reported count.
  localparam int SAT_W       = (CNT_W > PORT_CNT_W) ? CNT_W : PORT_CNT_W;
  localparam int PORT_CNT_MAX = (1 << PORT_CNT_W) - 1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PORTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_ADDR = 1'b1;
  localparam logic [MAX_W-1:0]     MAX_PORTS_RST = 9'd127;
  localparam logic [ADDR_W-1:0]    EXCL_ADDR_RST = 32'h0100_007F;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHARGER = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CHARGER = 3'd6;

  // One input word.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PORT_W-1:0] local_port;
    logic [ADDR_W-1:0] local_address;
    logic              is_listening;
    logic              charger_on;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  filter_enabled;
    logic [PORT_CNT_W-1:0] port_count;
    logic                  change_event;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_en;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_scan;
    logic scan_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/lpft_in_if.sv @@
// Input channel interface of the listening port filter table.
// Depends on lpft_pkg for the field widths.
`default_nettype none

interface lpft_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpft_pkg::CMD_W-1:0]    cmd;
  logic [lpft_pkg::PORT_W-1:0]   local_port;
  logic [lpft_pkg::ADDR_W-1:0]   local_address;
  logic                          is_listening;
  logic                          charger_on;

  modport source (output valid, cmd, local_port, local_address, is_listening, charger_on,
                  input ready);
  modport sink (input valid, cmd, local_port, local_address, is_listening, charger_on,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/lpft_out_if.sv @@
// Result channel interface of the listening port filter table.
// Depends on lpft_pkg for the field widths.
`default_nettype none

interface lpft_out_if;
  logic                              valid;
  logic                              ready;
  logic [lpft_pkg::STATUS_W-1:0]     status;
  logic                              filter_enabled;
  logic [lpft_pkg::PORT_CNT_W-1:0]   port_count;
  logic                              change_event;

  modport source (output valid, status, filter_enabled, port_count, change_event,
                  input ready);
  modport sink (input valid, status, filter_enabled, port_count, change_event,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/lpft_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lpft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/lpft_ctrl.sv @@
// Controller state machine of the listening port filter table.
// Depends on lpft_pkg for the command and status structs.
`default_nettype none

module lpft_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lpft_pkg::dp_status_t sts,
  output lpft_pkg::ctrl_cmd_t       cmd
);
  import lpft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.is_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lpft_dp.sv @@
// Datapath of the listening port filter table: configuration, port memory walk,
// valid bits, held count, filter flag and the result register.
// Depends on lpft_pkg and lpft_ram.
`default_nettype none

module lpft_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [lpft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lpft_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire lpft_pkg::in_item_t                 in_item,
  input  wire lpft_pkg::ctrl_cmd_t                cmd,
  output lpft_pkg::dp_status_t                    sts,
  output lpft_pkg::out_item_t                     out_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready
);
  import lpft_pkg::*;

  // Configuration registers.
  logic [MAX_W-1:0]  max_ports_r;
  logic [ADDR_W-1:0] excl_addr_r;

  // Latched word and its outcome so far.
  logic [CMD_W-1:0]    cmd_r;
  logic [PORT_W-1:0]   port_r;
  logic [STATUS_W-1:0] status_r;
  logic                change_r;

  // Table state.
  logic [TABLE_DEPTH-1:0] slot_valid_r;
  logic [CNT_W-1:0]       count_r;
  logic                   filter_on_r;
  logic                   charger_r;

  // Walk pipeline: issue index, compare index, first free slot.
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  // Result register.
  out_item_t out_item_r;
  logic      out_valid_r;

  logic [PORT_W-1:0] rd_port;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              eligible;
  logic              hit;
  logic              last;
  logic              free_now;
  logic              free_any;
  logic [SAT_W-1:0]  cnt_ext;
  logic              filter_calc;
  logic [PORT_CNT_W-1:0] cnt_sat;

  lpft_ram #(
    .WIDTH (PORT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (port_r),
    .raddr (scan_idx_r),
    .rdata (rd_port)
  );

  // A socket event is taken only for a listening socket on a real port
  // whose address is not the excluded one.
  assign eligible = ((in_item.cmd == CMD_REMOVE) || (in_item.cmd == CMD_ADD)) &&
                    in_item.is_listening &&
                    (in_item.local_address != excl_addr_r) &&
                    (in_item.local_port != '0);

  // Compare stage of the walk.
  assign hit      = cmp_vld_r && slot_valid_r[cmp_idx_r] && (rd_port == port_r);
  assign last     = cmp_vld_r && (cmp_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign free_now = cmp_vld_r && !slot_valid_r[cmp_idx_r];
  assign free_any = free_found_r || free_now;

  // An add that finds no duplicate writes the first free slot.
  assign ram_we    = cmd.scan_en && !hit && last && (cmd_r == CMD_ADD) && free_any;
  assign ram_waddr = free_found_r ? free_idx_r : cmp_idx_r;

  // Filter flag from the held count and the charger state.
  assign cnt_ext     = SAT_W'(count_r);
  assign filter_calc = !charger_r && (cnt_ext <= SAT_W'(max_ports_r));
  assign cnt_sat     = (cnt_ext > SAT_W'(PORT_CNT_MAX)) ? PORT_CNT_W'(PORT_CNT_MAX)
                                                          : cnt_ext[PORT_CNT_W-1:0];

  assign sts.is_scan  = eligible;
  assign sts.scan_end = cmd.scan_en && (hit || last);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ports_r <= MAX_PORTS_RST;
      excl_addr_r <= EXCL_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PORTS: max_ports_r <= cfg_wdata[MAX_W-1:0];
        CFG_EXCL_ADDR: excl_addr_r <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the word's command and port on accept; charger updates and ignored words resolve in the outcome block.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_item.cmd;
      port_r <= in_item.local_port;
    end
  end

  // Walk pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.accept) begin
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_en) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      cmp_vld_r  <= 1'b1;
      if (free_now && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      cmp_idx_r <= scan_idx_r;
      if (free_now && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // Outcome, valid bits, count, charger and filter flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      count_r      <= '0;
      filter_on_r  <= 1'b1;
      charger_r    <= 1'b0;
      status_r     <= ST_IGNORED;
      change_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (eligible) begin
          change_r <= 1'b1;
        end else if ((in_item.cmd == CMD_CHARGER) && filter_on_r) begin
          charger_r <= in_item.charger_on;
          status_r  <= ST_CHARGER;
          change_r  <= 1'b1;
        end else begin
          status_r <= ST_IGNORED;
          change_r <= 1'b0;
        end
      end
      if (cmd.scan_en) begin
        if (hit) begin
          if (cmd_r == CMD_REMOVE) begin
            slot_valid_r[cmp_idx_r] <= 1'b0;
            count_r                 <= count_r - CNT_W'(1);
            status_r                <= ST_REMOVED;
          end else begin
            status_r <= ST_PRESENT;
          end
        end else if (last) begin
          if (cmd_r == CMD_ADD) begin
            if (free_any) begin
              slot_valid_r[ram_waddr] <= 1'b1;
              count_r                 <= count_r + CNT_W'(1);
              status_r                <= ST_ADDED;
            end else begin
              status_r <= ST_FULL;
            end
          end else begin
            status_r <= ST_ABSENT;
          end
        end
      end
      if (cmd.load_out && change_r) begin
        filter_on_r <= filter_calc;
      end
    end
  end

  // Result register; it frees as soon as the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r.status         <= status_r;
      out_item_r.filter_enabled <= change_r ? filter_calc : filter_on_r;
      out_item_r.port_count     <= cnt_sat;
      out_item_r.change_event   <= change_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/listen_port_filter_table_unit.sv @@
// Listening port filter table: one word in flight at a time.
// A socket event that passes the checks walks the port memory, one slot a cycle, until
// its port is found or the last slot is compared. Ignored words and charger updates
// skip the walk and go straight to the result. The next word is taken once the
// result is in the output register. Reset (synchronous, rst_n low) clears the valid
// bits, the count and the charger state, sets the filter on and the config defaults.
// Depends on lpft_pkg, lpft_in_if, lpft_out_if, lpft_ram, lpft_ctrl and lpft_dp.
`default_nettype none

module listen_port_filter_table_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lpft_in_if.sink                              in_chan,
  lpft_out_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [lpft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpft_pkg::*;

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_sts;
  logic       in_ready;
  logic       out_valid;

  // Pack the input word.
  assign in_item.cmd           = in_chan.cmd;
  assign in_item.local_port    = in_chan.local_port;
  assign in_item.local_address = in_chan.local_address;
  assign in_item.is_listening  = in_chan.is_listening;
  assign in_item.charger_on    = in_chan.charger_on;
  assign in_chan.ready         = in_ready;

  lpft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (ctrl_cmd)
  );

  lpft_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (ctrl_cmd),
    .sts       (dp_sts),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_chan.ready)
  );

  // Unpack the result word.
  assign out_chan.valid          = out_valid;
  assign out_chan.status         = out_item.status;
  assign out_chan.filter_enabled = out_item.filter_enabled;
  assign out_chan.port_count     = out_item.port_count;
  assign out_chan.change_event   = out_item.change_event;

`ifndef SYNTHESIS
  // The result register is never overwritten while it still holds a word.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |-> dp_sts.out_free)
    else $error("result loaded over a waiting word");

  // A word is never accepted while the walk is running.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.scan_en |-> !in_chan.ready)
    else $error("input taken during the table walk");

  // An ignored word never raises a change notification.
  a_ignored_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_IGNORED)) |-> !out_chan.change_event)
    else $error("change raised for an ignored word");

  // A newly loaded result is visible in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |=> out_chan.valid)
    else $error("loaded result not shown");
`endif

endmodule

`default_nettype wire

@@ dv/tb_listen_port_filter_table_unit.sv @@
// Self-checking testbench for the listening port filter table unit.
// Drives socket and charger words through lpft_in_if and checks every result word on
// lpft_out_if against a behavioural table model. Depends on lpft_pkg, both interfaces and the unit.
`timescale 1ns / 100ps

module tb_listen_port_filter_table_unit;
  import lpft_pkg::*;

  // The command code that the block must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int TAIL_CYCLES  = TABLE_DEPTH + 40;
  localparam int MAX_REPORTS  = 40;
  localparam int POOL_SIZE    = 20;
  localparam int SEG_WORDS    = 20;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lpft_in_if  in_if ();
  lpft_out_if out_if ();

  listen_port_filter_table_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the table, the derived flags and the two registers.
  logic [PORT_W-1:0] slot_port [TABLE_DEPTH];
  bit                slot_used [TABLE_DEPTH];
  int unsigned       held_ports;
  bit                filter_flag;
  bit                charger_flag;
  logic [MAX_W-1:0]  max_ports_reg;
  logic [ADDR_W-1:0] excl_addr_reg;

  out_item_t         pending_results [$];
  logic [PORT_W-1:0] port_pool [POOL_SIZE];
  int unsigned       err_count;
  int unsigned       cycle_count;
  int unsigned       stall_left;
  bit                steady_flow;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < MAX_REPORTS)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // The filter is off while the charger is attached, else on up to the port limit.
  function automatic bit filter_from_state();
    return !charger_flag && (held_ports <= max_ports_reg);
  endfunction

  // Works out the result word for one accepted input word and advances the model.
  function automatic out_item_t table_outcome(input in_item_t w);
    out_item_t r;
    int        found;
    int        free_slot;
    r.status       = ST_IGNORED;
    r.change_event = 1'b0;
    if (w.cmd == CMD_ADD || w.cmd == CMD_REMOVE) begin
      if (w.is_listening && w.local_address != excl_addr_reg && w.local_port != '0) begin
        found     = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot_used[i] && slot_port[i] == w.local_port && found < 0) found = i;
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (w.cmd == CMD_ADD) begin
          if (found >= 0) begin
            r.status = ST_PRESENT;
          end else if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_port[free_slot] = w.local_port;
            slot_used[free_slot] = 1'b1;
            held_ports++;
            r.status = ST_ADDED;
          end
        end else if (found >= 0) begin
          slot_used[found] = 1'b0;
          held_ports--;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_ABSENT;
        end
        filter_flag    = filter_from_state();
        r.change_event = 1'b1;
      end
    end else if (w.cmd == CMD_CHARGER && filter_flag) begin
      charger_flag   = w.charger_on;
      filter_flag    = filter_from_state();
      r.status       = ST_CHARGER;
      r.change_event = 1'b1;
    end
    r.filter_enabled = filter_flag;
    r.port_count = (held_ports > PORT_CNT_MAX) ? PORT_CNT_W'(PORT_CNT_MAX)
                                               : PORT_CNT_W'(held_ports);
    return r;
  endfunction

  function automatic bit port_held(input logic [PORT_W-1:0] p);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_port[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  // A port the table holds, found from a random starting slot.
  function automatic logic [PORT_W-1:0] held_port_at_random();
    int start;
    start = $urandom_range(TABLE_DEPTH - 1, 0);
    for (int k = 0; k < TABLE_DEPTH; k++)
      if (slot_used[(start + k) % TABLE_DEPTH]) return slot_port[(start + k) % TABLE_DEPTH];
    return 16'd1;
  endfunction

  function automatic logic [PORT_W-1:0] absent_port();
    logic [PORT_W-1:0] p;
    do p = $urandom_range(65535, 1); while (port_held(p));
    return p;
  endfunction

  function automatic logic [ADDR_W-1:0] fresh_address();
    logic [ADDR_W-1:0] a;
    do a = $urandom; while (a == excl_addr_reg);
    return a;
  endfunction

  function automatic in_item_t make_word(input logic [CMD_W-1:0] cmd,
                                         input logic [PORT_W-1:0] port,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic listening, input logic charger);
    in_item_t w;
    w.cmd           = cmd;
    w.local_port    = port;
    w.local_address = addr;
    w.is_listening  = listening;
    w.charger_on    = charger;
    return w;
  endfunction

  function automatic logic [CMD_W-1:0] socket_cmd();
    return $urandom_range(1, 0) ? CMD_ADD : CMD_REMOVE;
  endfunction

  // Offers one word, with random gaps before it unless steady_flow is set, and records its result once taken.
  task automatic send_word(input in_item_t w);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99, 0) < 27) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.cmd           = w.cmd;
    in_if.local_port    = w.local_port;
    in_if.local_address = w.local_address;
    in_if.is_listening  = w.is_listening;
    in_if.charger_on    = w.charger_on;
    in_if.valid         = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(table_outcome(w));
  endtask

  // Stops offering and waits until every result word has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MAX_PORTS) max_ports_reg = data[MAX_W-1:0];
    else excl_addr_reg = data;
  endtask

  // Result sink: random back-pressure, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready = 1'b0;
    end else if (stall_left != 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = steady_flow || ($urandom_range(99, 0) >= 27);
    end
  end

  // Result checker: each result word is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", out_if.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", out_if.status, want.status);
        if (out_if.filter_enabled !== want.filter_enabled)
          report_mismatch("filter_enabled", out_if.filter_enabled, want.filter_enabled);
        if (out_if.port_count !== want.port_count)
          report_mismatch("port_count", out_if.port_count, want.port_count);
        if (out_if.change_event !== want.change_event)
          report_mismatch("change_event", out_if.change_event, want.change_event);
      end
    end
  end

  // Every status code but full and every reason to ignore a socket event, at reset settings.
  task automatic test_directed_events();
    send_word(make_word(CMD_UNUSED, 16'd5, 32'h0A00_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 16'd0, 32'h0A00_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 16'd80, 32'h0A00_0001, 1'b0, 1'b0));
    send_word(make_word(CMD_ADD, 16'd80, EXCL_ADDR_RST, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_word(make_word(CMD_ADD, 16'd1, 32'hC0A8_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_REMOVE, 16'd1234, 32'hC0A8_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_REMOVE, 16'hFFFF, 32'hC0A8_0001, 1'b0, 1'b0));
    send_word(make_word(CMD_REMOVE, 16'hFFFF, 32'hC0A8_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_REMOVE, 16'hFFFF, 32'hC0A8_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b0, 1'b0));
    send_word(make_word(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_word(make_word(CMD_REMOVE, 16'd1, 32'h7F00_0002, 1'b1, 1'b1));
  endtask

  // Port limit of zero turns the filter off as soon as one port is held.
  task automatic test_config_extremes();
    set_register(CFG_MAX_PORTS, 32'd0);
    set_register(CFG_EXCL_ADDR, 32'h0000_0000);
    send_word(make_word(CMD_ADD, 16'd22, 32'h0000_0000, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 16'd22, EXCL_ADDR_RST, 1'b1, 1'b0));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b1, 1'b0));
    send_word(make_word(CMD_REMOVE, 16'd22, 32'h7F00_0001, 1'b1, 1'b0));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b1, 1'b0));
    set_register(CFG_MAX_PORTS, 32'd256);
    set_register(CFG_EXCL_ADDR, 32'hFFFF_FFFF);
    send_word(make_word(CMD_ADD, 16'd443, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, 16'd443, 32'hFFFF_FFFE, 1'b1, 1'b0));
    send_word(make_word(CMD_REMOVE, 16'd443, 32'hFFFF_FFFE, 1'b1, 1'b0));
  endtask

  // Fills every slot without idling, probes the full table, then empties it.
  task automatic test_fill_and_drain_table();
    steady_flow = 1'b1;
    while (held_ports < TABLE_DEPTH) begin
      if (held_ports != 0 && $urandom_range(15, 0) == 0)
        send_word(make_word(CMD_ADD, held_port_at_random(), fresh_address(), 1'b1, 1'b0));
      else
        send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, $urandom));
    end
    send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, held_port_at_random(), fresh_address(), 1'b1, 1'b0));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b0, 1'b0));
    // One below a full table: the filter drops on the next event.
    set_register(CFG_MAX_PORTS, 32'd255);
    send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, 1'b0));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b0, 1'b0));
    send_word(make_word(CMD_REMOVE, held_port_at_random(), fresh_address(), 1'b1, 1'b0));
    send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, 1'b0));
    steady_flow = 1'b0;
    while (held_ports != 0) begin
      case ($urandom_range(15, 0))
        0: send_word(make_word(CMD_REMOVE, held_port_at_random(), fresh_address(), 1'b0,
                               1'b0));
        1: send_word(make_word(CMD_REMOVE, absent_port(), fresh_address(), 1'b1, 1'b0));
        default: send_word(make_word(CMD_REMOVE, held_port_at_random(), fresh_address(),
                                     1'b1, $urandom));
      endcase
    end
  endtask

  // The sink holds off for a long stretch while words keep being offered.
  task automatic test_output_stall();
    set_register(CFG_MAX_PORTS, 32'd2);
    stall_left = HOLD_CYCLES;
    for (int k = 0; k < 8; k++) begin
      if (k < 4)
        send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, 1'b0));
      else
        send_word(make_word(CMD_REMOVE, held_port_at_random(), fresh_address(), 1'b1, 1'b0));
    end
  endtask

  // Mostly well-formed socket events over a small port pool, plus charger and noise words.
  task automatic test_random_traffic();
    int                pick;
    logic [PORT_W-1:0] p;
    port_pool[0] = 16'd1;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) port_pool[i] = $urandom_range(65535, 1);
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          set_register(CFG_MAX_PORTS, $urandom_range(8, 1));
          set_register(CFG_EXCL_ADDR, $urandom);
        end
        1: begin
          set_register(CFG_MAX_PORTS, 32'd0);
          set_register(CFG_EXCL_ADDR, EXCL_ADDR_RST);
        end
        default: begin
          set_register(CFG_MAX_PORTS, 32'd256);
          set_register(CFG_EXCL_ADDR, 32'h0000_0000);
        end
      endcase
      for (int n = 0; n < SEG_WORDS; n++) begin
        pick = $urandom_range(99, 0);
        p    = port_pool[$urandom_range(POOL_SIZE - 1, 0)];
        if (pick < 70) begin
          if ($urandom_range(1, 0)) begin
            send_word(make_word(CMD_ADD, p, fresh_address(), 1'b1, $urandom));
          end else begin
            if (held_ports != 0 && $urandom_range(99, 0) < 60) p = held_port_at_random();
            send_word(make_word(CMD_REMOVE, p, fresh_address(), 1'b1, $urandom));
          end
        end else if (pick < 82) begin
          // Attaching the charger is left to the last test: it latches the filter off.
          send_word(make_word(CMD_CHARGER, $urandom, $urandom, $urandom, 1'b0));
        end else begin
          case ($urandom_range(3, 0))
            0: send_word(make_word(socket_cmd(), p, fresh_address(), 1'b0, $urandom));
            1: send_word(make_word(socket_cmd(), p, excl_addr_reg, 1'b1, $urandom));
            2: send_word(make_word(socket_cmd(), 16'd0, fresh_address(), 1'b1, $urandom));
            default: send_word(make_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom));
          endcase
        end
      end
    end
  endtask

  // Once the charger is attached the filter stays off and further updates are ignored.
  task automatic test_charger_latch();
    send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, 1'b0));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b0, 1'b1));
    send_word(make_word(CMD_CHARGER, 16'd0, 32'h0, 1'b0, 1'b0));
    send_word(make_word(CMD_ADD, absent_port(), fresh_address(), 1'b1, 1'b0));
    send_word(make_word(CMD_REMOVE, held_port_at_random(), fresh_address(), 1'b1, 1'b0));
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.cmd          = '0;
    in_if.local_port   = '0;
    in_if.local_address = '0;
    in_if.is_listening = 1'b0;
    in_if.charger_on   = 1'b0;
    out_if.ready       = 1'b0;
    err_count          = 0;
    cycle_count        = 0;
    stall_left         = 0;
    steady_flow        = 1'b0;

    // Model state after reset.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_port[i] = '0;
      slot_used[i] = 1'b0;
    end
    held_ports    = 0;
    filter_flag   = 1'b1;
    charger_flag  = 1'b0;
    max_ports_reg = MAX_PORTS_RST;
    excl_addr_reg = EXCL_ADDR_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_config_extremes();
    test_fill_and_drain_table();
    test_output_stall();
    test_random_traffic();
    test_charger_latch();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
